>>> hdl/bfp_pkg.sv
// Shared constants, codes and types for the MSB-first bit field packer.
package bfp_pkg;

  // Field and state widths
  localparam int unsigned DATA_W         = 64;
  localparam int unsigned MAX_FIELD_BITS = 64;
  localparam int unsigned CNT_W          = 7;
  localparam int unsigned CAP_W          = 21;
  localparam int unsigned USED_W         = 24;
  localparam int unsigned BYTE_W         = 8;
  localparam int unsigned FILL_W         = 3;
  localparam int unsigned NBYTES_W       = 4;
  localparam int unsigned WIN_W          = DATA_W + BYTE_W;

  // Capacity limits
  localparam logic [CAP_W-1:0] CAP_LIMIT = 21'd1048576;
  localparam logic [CAP_W-1:0] CAP_RESET = 21'd4096;

  // APB register file
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_CAPACITY = 1'b0;

  // Queue between front and back
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = 1;
  localparam int unsigned Q_CNT_W = 2;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_FLUSH = 1'b1
  } op_e;

  // One queued job: up to eight bytes, left aligned, or a drop marker
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [2:0]        cntm1;
    logic              drop;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_push_t;

endpackage

>>> hdl/bfp_if.sv
// Input channel interface for the bit field packer.
interface bfp_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [bfp_pkg::DATA_W-1:0]    field_value;
  logic [bfp_pkg::CNT_W-1:0]     bit_count;

  modport source (output valid, opcode, field_value, bit_count, input ready);
  modport sink   (input valid, opcode, field_value, bit_count, output ready);
endinterface

>>> hdl/bfp_out_if.sv
// Output channel interface for the bit field packer.
interface bfp_out_if;
  logic                       valid;
  logic                       ready;
  logic [bfp_pkg::BYTE_W-1:0] out_byte;
  logic                       byte_valid;
  logic                       dropped;
  logic                       last;

  modport source (output valid, out_byte, byte_valid, dropped, last, input ready);
  modport sink   (input valid, out_byte, byte_valid, dropped, last, output ready);
endinterface

>>> hdl/bfp_front.sv
// Front end: accepts items, checks capacity, packs bits and queues byte jobs.
module bfp_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  bfp_if.sink                      in_i,
  input  logic [bfp_pkg::CAP_W-1:0] cap_bytes_i,
  input  logic                     q_full_i,
  output bfp_pkg::q_push_t         push_o
);
  import bfp_pkg::*;

  logic [BYTE_W-1:0] partial_q, partial_d;
  logic [FILL_W-1:0] filled_q, filled_d;
  logic [USED_W-1:0] used_q, used_d;

  logic              accept;
  logic [CNT_W-1:0]  width;
  logic [CAP_W-1:0]  cap_eff;
  logic [USED_W-1:0] cap_bits;
  logic [USED_W:0]   need;
  logic              fits;
  logic [DATA_W-1:0] val_left;
  logic [WIN_W-1:0]  window;
  logic [WIN_W-1:0]  rest;
  logic [BYTE_W-1:0] total;
  logic [NBYTES_W-1:0] nbytes;

  assign in_i.ready = !q_full_i;
  assign accept     = in_i.valid && in_i.ready;

  // Clamp width and capacity, then check the write against the buffer
  assign width    = (in_i.bit_count > CNT_W'(MAX_FIELD_BITS)) ?
                    CNT_W'(MAX_FIELD_BITS) : in_i.bit_count;
  assign cap_eff  = (cap_bytes_i > CAP_LIMIT) ? CAP_LIMIT : cap_bytes_i;
  assign cap_bits = {cap_eff, 3'b000};
  assign need     = {1'b0, used_q} + (USED_W+1)'(width);
  assign fits     = need <= {1'b0, cap_bits};

  // Left-align the field under the pending bits; upper junk bits fall off
  assign val_left = in_i.field_value << (CNT_W'(DATA_W) - width);
  assign window   = {partial_q, {DATA_W{1'b0}}} | ({val_left, {BYTE_W{1'b0}}} >> filled_q);
  assign total    = BYTE_W'(filled_q) + BYTE_W'(width);
  assign nbytes   = total[6:3];
  assign rest     = window << {nbytes, 3'b000};

  // Classify the item and compute the next state
  always_comb begin
    partial_d    = partial_q;
    filled_d     = filled_q;
    used_d       = used_q;
    push_o       = '0;
    if (accept) begin
      if (op_e'(in_i.opcode) == OP_FLUSH) begin
        if (filled_q != '0) begin
          push_o.valid       = 1'b1;
          push_o.entry.data  = {partial_q, {(DATA_W-BYTE_W){1'b0}}};
          push_o.entry.cntm1 = '0;
          push_o.entry.drop  = 1'b0;
          used_d    = used_q + USED_W'(BYTE_W - 32'(filled_q));
          partial_d = '0;
          filled_d  = '0;
        end
      end else if (width != '0) begin
        if (!fits) begin
          push_o.valid       = 1'b1;
          push_o.entry.data  = '0;
          push_o.entry.cntm1 = '0;
          push_o.entry.drop  = 1'b1;
        end else begin
          push_o.valid       = nbytes != '0;
          push_o.entry.data  = window[WIN_W-1:BYTE_W];
          push_o.entry.cntm1 = 3'(nbytes - 4'd1);
          push_o.entry.drop  = 1'b0;
          partial_d = rest[WIN_W-1:DATA_W];
          filled_d  = total[2:0];
          used_d    = used_q + USED_W'(width);
        end
      end
    end
  end

  // Packer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q <= '0;
      filled_q  <= '0;
      used_q    <= '0;
    end else begin
      partial_q <= partial_d;
      filled_q  <= filled_d;
      used_q    <= used_d;
    end
  end

endmodule

>>> hdl/bfp_queue.sv
// Short job queue between the front end and the byte drain.
module bfp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bfp_pkg::q_push_t    push_i,
  input  logic                pop_i,
  output logic                full_o,
  output logic                valid_o,
  output bfp_pkg::q_entry_t   head_o
);
  import bfp_pkg::*;

  q_entry_t             mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_q, wr_d;
  logic [Q_PTR_W-1:0]   rd_q, rd_d;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 do_pop;

  assign full_o  = cnt_q == Q_CNT_W'(Q_DEPTH);
  assign valid_o = cnt_q != '0;
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  // Pointer and count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i.valid) begin
      wr_d = wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = rd_q + 1'b1;
    end
    case ({push_i.valid, do_pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_q] <= push_i.entry;
    end
  end

endmodule

>>> hdl/bfp_back.sv
// Back end: drains queued jobs into an output register, one byte per cycle unless stalled.
module bfp_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  bfp_pkg::q_entry_t   head_i,
  output logic                pop_o,
  bfp_out_if.source           out_o
);
  import bfp_pkg::*;

  logic              ovalid_q, ovalid_d;
  logic [2:0]        idx_q, idx_d;
  logic [BYTE_W-1:0] byte_q;
  logic              bvalid_q;
  logic              drop_q;
  logic              last_q;
  logic              load;
  logic              is_last;
  logic [DATA_W-1:0] sel;

  assign load    = q_valid_i && (!ovalid_q || out_o.ready);
  assign is_last = idx_q == head_i.cntm1;
  assign sel     = head_i.data << {idx_q, 3'b000};
  assign pop_o   = load && is_last;

  // Byte index and output valid
  always_comb begin
    idx_d    = idx_q;
    ovalid_d = ovalid_q;
    if (load) begin
      ovalid_d = 1'b1;
      idx_d    = is_last ? '0 : idx_q + 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      ovalid_q <= ovalid_d;
      idx_q    <= idx_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q   <= sel[DATA_W-1:DATA_W-BYTE_W];
      bvalid_q <= !head_i.drop;
      drop_q   <= head_i.drop;
      last_q   <= is_last;
    end
  end

  assign out_o.valid      = ovalid_q;
  assign out_o.out_byte   = byte_q;
  assign out_o.byte_valid = bvalid_q;
  assign out_o.dropped    = drop_q;
  assign out_o.last       = last_q;

endmodule

>>> hdl/msb_first_bit_field_packer_core.sv
// Top level: packs MSB-first bit fields into a byte stream with APB capacity register.
// An item's first result passes through the job queue and then the output register.
// Throughput: one item accepted per cycle while the two-entry job queue has room; the
// byte drain emits one result per cycle while the output is not stalled, and an item
// yields up to 8 results (for a 64-bit field). Reset clears packer state, queue and
// output valid, and loads capacity_bytes with 4096.
module msb_first_bit_field_packer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bfp_if.sink                          in_i,
  bfp_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bfp_pkg::APB_AW-1:0]   paddr,
  input  logic [bfp_pkg::APB_DW-1:0]   pwdata,
  output logic [bfp_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import bfp_pkg::*;

  logic [CAP_W-1:0] cap_q;
  logic             cfg_wr;
  q_push_t          push;
  q_entry_t         head;
  logic             q_full;
  logic             q_valid;
  logic             pop;

  // APB register access
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_CAPACITY);
  assign prdata = (paddr[2] == REG_CAPACITY) ? APB_DW'(cap_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_wr) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  bfp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cap_bytes_i (cap_q),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  bfp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .head_o  (head)
  );

  bfp_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .head_i    (head),
    .pop_o     (pop),
    .out_o     (out_o)
  );

endmodule
